### rtl/qct_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// qct_pkg
// shared types, token codes and keyword tables for the query command tokenizer
// ----------------------------------------------------------------------------
package qct_pkg;

   localparam int KW_COUNT = 9;

   // token kinds
   localparam logic [3:0] TK_NAME      = 4'd9;
   localparam logic [3:0] TK_POINT     = 4'd10;
   localparam logic [3:0] TK_INTEGER   = 4'd11;
   localparam logic [3:0] TK_COMMA     = 4'd12;
   localparam logic [3:0] TK_SEMICOLON = 4'd13;
   localparam logic [3:0] TK_END       = 4'd14;
   localparam logic [3:0] TK_ERROR     = 4'd15;

   // error causes
   localparam logic [1:0] EC_NONE      = 2'd0;
   localparam logic [1:0] EC_BAD_CHAR  = 2'd1;
   localparam logic [1:0] EC_BAD_POINT = 2'd2;
   localparam logic [1:0] EC_TOO_LARGE = 2'd3;

   localparam int DEF_MAX_NAME_LEN = 32;
   localparam int DEF_NUMBER_BITS  = 32;

   typedef enum logic [3:0] {
      CL_ALPHA, CL_DIGIT, CL_UNDERSCORE, CL_SPACE, CL_LPAREN, CL_RPAREN,
      CL_COMMA, CL_SEMI, CL_PLUS, CL_MINUS, CL_OTHER
   } qct_class_type;

   typedef enum logic [2:0] {
      M_IDLE, M_WORD, M_NUMBER, M_POINT, M_ERROR
   } qct_mode_type;

   typedef enum logic [1:0] {
      B_SCAN, B_RUN_ADDR, B_RUN_EMIT
   } qct_back_state_type;

   typedef struct packed {
      logic [7:0]    ch;
      logic          eot;
      qct_class_type cls;
   } qct_item_type;

   typedef struct packed {
      logic [3:0]  kind;
      logic [1:0]  cause;
      logic [31:0] first;
      logic [31:0] second;
      logic [7:0]  name_char;
      logic        last;
   } qct_result_type;

   function automatic logic [3:0] kw_len(input logic [3:0] k);
      case (k)
         4'd0: kw_len = 4'd6;
         4'd1: kw_len = 4'd6;
         4'd2: kw_len = 4'd10;
         4'd3: kw_len = 4'd8;
         4'd4: kw_len = 4'd6;
         4'd5: kw_len = 4'd5;
         4'd6: kw_len = 4'd6;
         4'd7: kw_len = 4'd7;
         4'd8: kw_len = 4'd2;
         default: kw_len = 4'd0;
      endcase
   endfunction

   // lower-case keyword character at position p
   function automatic logic [7:0] kw_char(input logic [3:0] k, input logic [3:0] p);
      logic [79:0] s;
      case (k)
         4'd0: s = {"create", 32'h0};
         4'd1: s = {"insert", 32'h0};
         4'd2: s = {"print", "_tree"};
         4'd3: s = {"contains", 16'h0};
         4'd4: s = {"search", 32'h0};
         4'd5: s = {"where", 40'h0};
         4'd6: s = {"inside", 32'h0};
         4'd7: s = {"left_of", 24'h0};
         4'd8: s = {"nn", 64'h0};
         default: s = '0;
      endcase
      if (p < 4'd10) kw_char = s[79 - 8 * int'(p) -: 8];
      else kw_char = 8'h00;
   endfunction

endpackage

### rtl/qct_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// qct_ram
// generic single write port ram with registered read
// ----------------------------------------------------------------------------
module qct_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 32
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);
   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) mem_ff[wr_addr] <= wr_data;
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;
endmodule

### rtl/qct_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// qct_front
// accepts text bytes, classifies them and queues them for the scanner
// ----------------------------------------------------------------------------
module qct_front (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_ready,
   input  logic [7:0]           req_char_code,
   input  logic                 req_end_of_text,
   output logic                 head_valid,
   output qct_pkg::qct_item_type head,
   input  logic                 pop
);
   import qct_pkg::*;

   qct_item_type entry_ff [2];
   logic         wr_ptr_ff, wr_ptr_in;
   logic         rd_ptr_ff, rd_ptr_in;
   logic [1:0]   count_ff, count_in;
   qct_item_type item;
   logic         push;

   always_comb begin
      item.ch  = req_char_code;
      item.eot = req_end_of_text;
      case (req_char_code) inside
         [8'h61:8'h7A], [8'h41:8'h5A]: item.cls = CL_ALPHA;
         [8'h30:8'h39]:                item.cls = CL_DIGIT;
         8'h5F:                        item.cls = CL_UNDERSCORE;
         8'h20, [8'h09:8'h0D]:         item.cls = CL_SPACE;
         8'h28:                        item.cls = CL_LPAREN;
         8'h29:                        item.cls = CL_RPAREN;
         8'h2C:                        item.cls = CL_COMMA;
         8'h3B:                        item.cls = CL_SEMI;
         8'h2B:                        item.cls = CL_PLUS;
         8'h2D:                        item.cls = CL_MINUS;
         default:                      item.cls = CL_OTHER;
      endcase
   end

   assign req_ready  = (count_ff != 2'd2);
   assign push       = req_valid && req_ready;
   assign head_valid = (count_ff != 2'd0);
   assign head       = entry_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff ^ push;
      rd_ptr_in = rd_ptr_ff ^ pop;
      count_in  = count_ff + 2'(push) - 2'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) entry_ff[wr_ptr_ff] <= item;
   end
endmodule

### rtl/qct_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// qct_back
// scanner: word, number and point state machine, name run playback
// ----------------------------------------------------------------------------
module qct_back #(
   parameter int MAX_NAME_LEN = qct_pkg::DEF_MAX_NAME_LEN,
   parameter int NUMBER_BITS  = qct_pkg::DEF_NUMBER_BITS
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   head_valid,
   input  qct_pkg::qct_item_type  head,
   output logic                   pop,
   input  logic                   slot_free,
   output logic                   emit,
   output qct_pkg::qct_result_type res
);
   import qct_pkg::*;

   localparam int WL_W     = $clog2(MAX_NAME_LEN + 1);
   localparam int AW       = $clog2(MAX_NAME_LEN);
   localparam int EFF_BITS = (NUMBER_BITS > 32) ? 32 : NUMBER_BITS;
   localparam logic [35:0] POS_LIMIT = (36'd1 << (EFF_BITS - 1)) - 36'd1;

   qct_back_state_type state_ff, state_in;
   qct_mode_type       mode_ff, mode_in;
   logic [WL_W-1:0]    wl_ff, wl_in;
   logic [8:0]         match_ff, match_in;
   logic [31:0]        acc_ff, acc_in;
   logic               ovf_ff, ovf_in;
   logic [3:0]         phase_ff, phase_in;
   logic [1:0]         negf_ff, negf_in;
   logic [31:0]        xh_ff, xh_in;
   logic [AW-1:0]      run_idx_ff, run_idx_in;

   logic               wr_en;
   logic [7:0]         rd_data;

   logic               follow_empty, word_char, point_off, neg, closer, run_last;
   logic [2:0]         sub;
   logic [7:0]         lc;
   logic [WL_W-1:0]    wl_base;
   logic [8:0]         mask_add;
   logic               kw_found;
   logic [3:0]         kw_idx;
   logic [35:0]        acc_v, acc_lim;
   logic [3:0]         digit;
   logic [31:0]        signed_val;

   qct_ram #(.WIDTH(8), .DEPTH(MAX_NAME_LEN)) u_store (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wl_base[AW-1:0]),
      .wr_data (head.ch),
      .rd_addr (run_idx_ff),
      .rd_data (rd_data)
   );

   // per-byte helpers
   always_comb begin
      follow_empty = !head.eot && (head.cls inside {CL_ALPHA, CL_DIGIT, CL_LPAREN, CL_SPACE});
      word_char    = head.cls inside {CL_ALPHA, CL_DIGIT, CL_UNDERSCORE};
      lc           = (head.cls == CL_ALPHA) ? (head.ch | 8'h20) : head.ch;
      digit        = head.ch[3:0];
      wl_base      = (mode_ff == M_IDLE) ? '0 : wl_ff;
      mask_add     = (mode_ff == M_IDLE) ? 9'h1FF : match_ff;
      for (int k = 0; k < KW_COUNT; k++) begin
         if (wl_base >= WL_W'(kw_len(4'(k))) || lc != kw_char(4'(k), wl_base[3:0]))
            mask_add[k] = 1'b0;
      end
      kw_found = 1'b0;
      kw_idx   = 4'd0;
      for (int k = KW_COUNT - 1; k >= 0; k--) begin
         if (match_ff[k] && wl_ff == WL_W'(kw_len(4'(k)))) begin
            kw_found = 1'b1;
            kw_idx   = 4'(k);
         end
      end
      point_off  = (phase_ff >= 4'd5);
      sub        = 3'(phase_ff - (point_off ? 4'd5 : 4'd0));
      neg        = point_off ? negf_ff[1] : negf_ff[0];
      closer     = point_off ? (head.cls == CL_RPAREN) : (head.cls == CL_COMMA);
      acc_v      = ({4'b0, acc_ff} << 3) + ({4'b0, acc_ff} << 1) + 36'(digit);
      acc_lim    = POS_LIMIT + 36'((mode_ff == M_POINT) && neg);
      signed_val = neg ? (32'd0 - acc_ff) : acc_ff;
      run_last   = (WL_W'(run_idx_ff) == wl_ff - WL_W'(1));
   end

   always_comb begin
      state_in   = state_ff;
      mode_in    = mode_ff;
      wl_in      = wl_ff;
      match_in   = match_ff;
      acc_in     = acc_ff;
      ovf_in     = ovf_ff;
      phase_in   = phase_ff;
      negf_in    = negf_ff;
      xh_in      = xh_ff;
      run_idx_in = run_idx_ff;
      pop        = 1'b0;
      emit       = 1'b0;
      wr_en      = 1'b0;
      res        = '0;

      case (state_ff)
         B_SCAN: begin
            if (head_valid && slot_free) begin
               if (mode_ff == M_ERROR || (mode_ff == M_IDLE && head.eot)) begin
                  pop = 1'b1;
                  if (head.eot) begin
                     emit     = 1'b1;
                     res.kind = TK_END;
                     res.last = 1'b1;
                     mode_in  = M_IDLE;
                     wl_in    = '0;
                     match_in = 9'h1FF;
                     acc_in   = '0;
                     ovf_in   = 1'b0;
                     phase_in = '0;
                     negf_in  = '0;
                     xh_in    = '0;
                  end
               end else if (mode_ff == M_WORD && (head.eot || !word_char)) begin
                  // flush the word, the byte is handled again from idle
                  mode_in = M_IDLE;
                  if (kw_found) begin
                     emit     = 1'b1;
                     res.kind = kw_idx;
                     res.last = follow_empty;
                  end else begin
                     run_idx_in = '0;
                     state_in   = B_RUN_ADDR;
                  end
               end else if (mode_ff == M_NUMBER && (head.eot || head.cls != CL_DIGIT)) begin
                  emit = 1'b1;
                  if (ovf_ff) begin
                     res.kind  = TK_ERROR;
                     res.cause = EC_TOO_LARGE;
                     res.last  = !head.eot;
                     mode_in   = M_ERROR;
                     pop       = !head.eot;
                  end else begin
                     res.kind  = TK_INTEGER;
                     res.first = acc_ff;
                     res.last  = follow_empty;
                     mode_in   = M_IDLE;
                  end
               end else if (mode_ff == M_POINT && head.eot) begin
                  emit      = 1'b1;
                  res.kind  = TK_ERROR;
                  res.cause = EC_BAD_POINT;
                  mode_in   = M_ERROR;
               end else begin
                  pop = 1'b1;
                  case (mode_ff)
                     M_WORD: begin
                        if (wl_ff >= WL_W'(MAX_NAME_LEN)) begin
                           emit      = 1'b1;
                           res.kind  = TK_ERROR;
                           res.cause = EC_TOO_LARGE;
                           res.last  = 1'b1;
                           mode_in   = M_ERROR;
                        end else begin
                           wr_en    = 1'b1;
                           match_in = mask_add;
                           wl_in    = wl_ff + WL_W'(1);
                        end
                     end
                     M_NUMBER: begin
                        if (!ovf_ff) begin
                           if (acc_v > acc_lim) ovf_in = 1'b1;
                           else acc_in = acc_v[31:0];
                        end
                     end
                     M_POINT: begin
                        if (sub == 3'd0) begin
                           if (head.cls == CL_SPACE) begin
                              // skipped
                           end else if (head.cls == CL_PLUS || head.cls == CL_MINUS) begin
                              if (head.cls == CL_MINUS) begin
                                 if (point_off) negf_in[1] = 1'b1;
                                 else negf_in[0] = 1'b1;
                              end
                              phase_in = phase_ff + 4'd1;
                           end else if (head.cls == CL_DIGIT) begin
                              acc_in   = 32'(digit);
                              phase_in = phase_ff + ((digit == 4'd0) ? 4'd2 : 4'd3);
                           end else begin
                              emit      = 1'b1;
                              res.kind  = TK_ERROR;
                              res.cause = EC_BAD_POINT;
                              res.last  = 1'b1;
                              mode_in   = M_ERROR;
                           end
                        end else if (sub == 3'd1) begin
                           if (head.cls == CL_DIGIT && digit != 4'd0) begin
                              acc_in   = 32'(digit);
                              phase_in = phase_ff + 4'd2;
                           end else begin
                              emit      = 1'b1;
                              res.kind  = TK_ERROR;
                              res.cause = EC_BAD_POINT;
                              res.last  = 1'b1;
                              mode_in   = M_ERROR;
                           end
                        end else if (sub == 3'd3 && head.cls == CL_DIGIT) begin
                           if (!ovf_ff) begin
                              if (acc_v > acc_lim) ovf_in = 1'b1;
                              else acc_in = acc_v[31:0];
                           end
                        end else if (head.cls == CL_SPACE && sub <= 3'd4) begin
                           phase_in = point_off ? 4'd9 : 4'd4;
                        end else if (closer && sub <= 3'd4) begin
                           if (!point_off) begin
                              xh_in    = signed_val;
                              acc_in   = '0;
                              phase_in = 4'd5;
                           end else if (ovf_ff) begin
                              emit      = 1'b1;
                              res.kind  = TK_ERROR;
                              res.cause = EC_TOO_LARGE;
                              res.last  = 1'b1;
                              mode_in   = M_ERROR;
                           end else begin
                              emit       = 1'b1;
                              res.kind   = TK_POINT;
                              res.first  = xh_ff;
                              res.second = signed_val;
                              res.last   = 1'b1;
                              mode_in    = M_IDLE;
                           end
                        end else begin
                           emit      = 1'b1;
                           res.kind  = TK_ERROR;
                           res.cause = EC_BAD_POINT;
                           res.last  = 1'b1;
                           mode_in   = M_ERROR;
                        end
                     end
                     default: begin
                        case (head.cls)
                           CL_ALPHA: begin
                              mode_in  = M_WORD;
                              wr_en    = 1'b1;
                              match_in = mask_add;
                              wl_in    = WL_W'(1);
                           end
                           CL_DIGIT: begin
                              mode_in = M_NUMBER;
                              acc_in  = 32'(digit);
                              ovf_in  = 1'b0;
                           end
                           CL_LPAREN: begin
                              mode_in  = M_POINT;
                              phase_in = '0;
                              negf_in  = '0;
                              acc_in   = '0;
                              ovf_in   = 1'b0;
                           end
                           CL_SPACE: begin
                           end
                           CL_COMMA: begin
                              emit     = 1'b1;
                              res.kind = TK_COMMA;
                              res.last = 1'b1;
                           end
                           CL_SEMI: begin
                              emit     = 1'b1;
                              res.kind = TK_SEMICOLON;
                              res.last = 1'b1;
                           end
                           default: begin
                              emit      = 1'b1;
                              res.kind  = TK_ERROR;
                              res.cause = EC_BAD_CHAR;
                              res.last  = 1'b1;
                              mode_in   = M_ERROR;
                           end
                        endcase
                     end
                  endcase
               end
            end
         end
         B_RUN_ADDR: state_in = B_RUN_EMIT;
         B_RUN_EMIT: begin
            if (slot_free) begin
               emit          = 1'b1;
               res.kind      = TK_NAME;
               res.name_char = rd_data;
               res.last      = run_last && follow_empty;
               if (run_last) begin
                  state_in = B_SCAN;
               end else begin
                  run_idx_in = run_idx_ff + AW'(1);
                  state_in   = B_RUN_ADDR;
               end
            end
         end
         default: state_in = B_SCAN;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= B_SCAN;
         mode_ff    <= M_IDLE;
         wl_ff      <= '0;
         match_ff   <= 9'h1FF;
         acc_ff     <= '0;
         ovf_ff     <= 1'b0;
         phase_ff   <= '0;
         negf_ff    <= '0;
         xh_ff      <= '0;
         run_idx_ff <= '0;
      end else begin
         state_ff   <= state_in;
         mode_ff    <= mode_in;
         wl_ff      <= wl_in;
         match_ff   <= match_in;
         acc_ff     <= acc_in;
         ovf_ff     <= ovf_in;
         phase_ff   <= phase_in;
         negf_ff    <= negf_in;
         xh_ff      <= xh_in;
         run_idx_ff <= run_idx_in;
      end
   end
endmodule

### rtl/query_command_tokenizer_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// query_command_tokenizer_core
// splits query text into keyword, name, integer, point and punctuation tokens
// ----------------------------------------------------------------------------
// channel  direction  transaction
// req_     in         one text byte or end-of-text marker
// rsp_     out        one token (or one character of a set name)
//
// a byte that gives at most one token is popped when the output register is free
// a byte that ends a word or an integer that fits stays queued until the flushed token is out
// a set name plays back from the word store, each character through an address state and then an emit state
// a two-entry queue lets the input side keep accepting while the scanner stalls
// the output register holds a finished token while the scanner moves on
// synchronous reset returns everything to idle; the word store is not cleared
// ----------------------------------------------------------------------------
module query_command_tokenizer_core #(
   parameter int MAX_NAME_LEN = qct_pkg::DEF_MAX_NAME_LEN,
   parameter int NUMBER_BITS  = qct_pkg::DEF_NUMBER_BITS
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_ready,
   input  logic [7:0]         req_char_code,
   input  logic               req_end_of_text,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output logic [3:0]         rsp_token_kind,
   output logic [1:0]         rsp_error_cause,
   output logic signed [31:0] rsp_first_number,
   output logic signed [31:0] rsp_second_number,
   output logic [7:0]         rsp_name_char,
   output logic               rsp_last_of_run
);
   import qct_pkg::*;

   qct_item_type   head;
   logic           head_valid, pop;
   logic           slot_free, emit;
   qct_result_type res;

   logic           rsp_valid_ff, rsp_valid_in;
   qct_result_type rsp_ff;

   // front: classify and queue
   qct_front u_front (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_ready       (req_ready),
      .req_char_code   (req_char_code),
      .req_end_of_text (req_end_of_text),
      .head_valid      (head_valid),
      .head            (head),
      .pop             (pop)
   );

   // back: scanner
   qct_back #(
      .MAX_NAME_LEN (MAX_NAME_LEN),
      .NUMBER_BITS  (NUMBER_BITS)
   ) u_back (
      .clock      (clock),
      .reset      (reset),
      .head_valid (head_valid),
      .head       (head),
      .pop        (pop),
      .slot_free  (slot_free),
      .emit       (emit),
      .res        (res)
   );

   // output register frees when empty or being taken
   assign slot_free = !rsp_valid_ff || rsp_ready;

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (slot_free) rsp_valid_in = emit;
   end

   always_ff @(posedge clock) begin
      if (reset) rsp_valid_ff <= 1'b0;
      else rsp_valid_ff <= rsp_valid_in;
   end

   always_ff @(posedge clock) begin
      if (slot_free && emit) rsp_ff <= res;
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_token_kind    = rsp_ff.kind;
   assign rsp_error_cause   = rsp_ff.cause;
   assign rsp_first_number  = rsp_ff.first;
   assign rsp_second_number = rsp_ff.second;
   assign rsp_name_char     = rsp_ff.name_char;
   assign rsp_last_of_run   = rsp_ff.last;

   // error tokens always carry a cause, other tokens never do
   a_cause: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> ((rsp_token_kind == TK_ERROR) == (rsp_error_cause != EC_NONE)))
      else $error("error cause does not match token kind");

   // only point tokens carry a second number
   a_second: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_token_kind != TK_POINT |-> rsp_second_number == 32'sd0)
      else $error("second number set outside a point token");

   // only name tokens carry a character
   a_char: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_token_kind != TK_NAME |-> rsp_name_char == 8'h00)
      else $error("name character set outside a name token");

   // end token always closes its run
   a_end: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_token_kind == TK_END |-> rsp_last_of_run)
      else $error("end token not marked last");
endmodule

### tb/sv/query_command_tokenizer_core_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// query_command_tokenizer_core_checker
// watches both channels, predicts the tokens of every accepted byte and
// compares each result transaction with the oldest predicted token
// ----------------------------------------------------------------------------
module query_command_tokenizer_core_checker (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   input  logic               req_ready,
   input  logic [7:0]         req_char_code,
   input  logic               req_end_of_text,
   input  logic               rsp_valid,
   input  logic               rsp_ready,
   input  logic [3:0]         rsp_token_kind,
   input  logic [1:0]         rsp_error_cause,
   input  logic signed [31:0] rsp_first_number,
   input  logic signed [31:0] rsp_second_number,
   input  logic [7:0]         rsp_name_char,
   input  logic               rsp_last_of_run,
   output int                 fail_count,
   output int                 pending_tokens,
   output int                 token_count,
   output int                 error_tokens,
   output int                 point_tokens
);
   import qct_pkg::*;

   localparam int NAME_MAX = DEF_MAX_NAME_LEN;
   localparam logic [31:0] POS_LIMIT = 32'h7fff_ffff;

   qct_result_type token_queue[$];
   qct_result_type step_tokens[$];

   qct_mode_type mode;
   logic [7:0]   word_buf [NAME_MAX];
   int           word_len;
   logic [8:0]   kw_alive;
   logic [31:0]  acc;
   logic         acc_ovf;
   logic [3:0]   pt_phase;
   logic [1:0]   pt_neg;
   logic [31:0]  pt_x;

   assign pending_tokens = token_queue.size();

   function automatic string kw_name(input int k);
      case (k)
         0: return "create";
         1: return "insert";
         2: return {"print", "_tree"};
         3: return "contains";
         4: return "search";
         5: return "where";
         6: return "inside";
         7: return "left_of";
         default: return "nn";
      endcase
   endfunction

   function automatic bit is_alpha(input logic [7:0] c);
      return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z");
   endfunction
   function automatic bit is_digit(input logic [7:0] c);
      return c >= "0" && c <= "9";
   endfunction
   function automatic bit is_space(input logic [7:0] c);
      return c == " " || (c >= 8'd9 && c <= 8'd13);
   endfunction

   task automatic push_token(input logic [3:0] kind, input logic [1:0] cause,
                             input logic [31:0] a, input logic [31:0] b,
                             input logic [7:0] ch);
      qct_result_type t;
      t.kind = kind; t.cause = cause; t.first = a; t.second = b;
      t.name_char = ch; t.last = 1'b0;
      step_tokens.push_back(t);
   endtask

   task automatic raise_error(input logic [1:0] cause);
      push_token(TK_ERROR, cause, '0, '0, '0);
      mode = M_ERROR;
   endtask

   task automatic clear_state();
      mode = M_IDLE; word_len = 0; kw_alive = '1; acc = '0; acc_ovf = 1'b0;
      pt_phase = '0; pt_neg = '0; pt_x = '0;
   endtask

   task automatic add_digit(input logic [7:0] c, input bit neg);
      logic [63:0] v;
      logic [63:0] lim;
      lim = {32'h0, POS_LIMIT} + (neg ? 64'd1 : 64'd0);
      v = {32'h0, acc} * 64'd10 + 64'(c - "0");
      if (acc_ovf) return;
      if (v > lim) acc_ovf = 1'b1;
      else acc = v[31:0];
   endtask

   task automatic add_letter(input logic [7:0] c);
      logic [7:0] lc;
      string kw;
      if (word_len >= NAME_MAX) begin
         raise_error(EC_TOO_LARGE);
         return;
      end
      lc = (c >= "A" && c <= "Z") ? c + 8'd32 : c;
      for (int k = 0; k < KW_COUNT; k++) begin
         kw = kw_name(k);
         if (word_len >= kw.len() || lc != kw[word_len]) kw_alive[k] = 1'b0;
      end
      word_buf[word_len] = c;
      word_len++;
   endtask

   task automatic close_word();
      string kw;
      mode = M_IDLE;
      for (int k = 0; k < KW_COUNT; k++) begin
         kw = kw_name(k);
         if (kw_alive[k] && word_len == kw.len()) begin
            push_token(4'(k), EC_NONE, '0, '0, '0);
            return;
         end
      end
      for (int i = 0; i < word_len; i++) push_token(TK_NAME, EC_NONE, '0, '0, word_buf[i]);
   endtask

   task automatic start_token(input logic [7:0] c);
      if (is_alpha(c)) begin
         mode = M_WORD; word_len = 0; kw_alive = '1;
         add_letter(c);
      end else if (is_digit(c)) begin
         mode = M_NUMBER; acc = 32'(c - "0"); acc_ovf = 1'b0;
      end else if (c == "(") begin
         mode = M_POINT; pt_phase = '0; pt_neg = '0; acc = '0; acc_ovf = 1'b0;
      end else if (is_space(c)) begin
      end else if (c == ",") begin
         push_token(TK_COMMA, EC_NONE, '0, '0, '0);
      end else if (c == ";") begin
         push_token(TK_SEMICOLON, EC_NONE, '0, '0, '0);
      end else begin
         raise_error(EC_BAD_CHAR);
      end
   endtask

   task automatic point_byte(input logic [7:0] c);
      logic [3:0]  off;
      logic [3:0]  sub;
      logic [1:0]  bitm;
      bit          neg;
      logic [7:0]  closer;
      logic [31:0] v;
      off = (pt_phase >= 4'd5) ? 4'd5 : 4'd0;
      sub = pt_phase - off;
      bitm = off != 0 ? 2'b10 : 2'b01;
      neg = (pt_neg & bitm) != 0;
      closer = off != 0 ? ")" : ",";
      if (sub == 0) begin
         if (is_space(c)) return;
         if (c == "+" || c == "-") begin
            if (c == "-") pt_neg |= bitm;
            pt_phase = off + 4'd1;
         end else if (c == "0") begin
            acc = '0; pt_phase = off + 4'd2;
         end else if (is_digit(c)) begin
            acc = 32'(c - "0"); pt_phase = off + 4'd3;
         end else begin
            raise_error(EC_BAD_POINT);
         end
      end else if (sub == 1) begin
         if (is_digit(c) && c != "0") begin
            acc = 32'(c - "0"); pt_phase = off + 4'd3;
         end else begin
            raise_error(EC_BAD_POINT);
         end
      end else if (sub == 3 && is_digit(c)) begin
         add_digit(c, neg);
      end else if (is_space(c) && sub <= 4) begin
         pt_phase = off + 4'd4;
      end else if (c == closer && sub <= 4) begin
         v = neg ? 32'd0 - acc : acc;
         if (off == 0) begin
            pt_x = v; acc = '0; pt_phase = 4'd5;
         end else if (acc_ovf) begin
            raise_error(EC_TOO_LARGE);
         end else begin
            push_token(TK_POINT, EC_NONE, pt_x, v, '0);
            mode = M_IDLE;
         end
      end else begin
         raise_error(EC_BAD_POINT);
      end
   endtask

   task automatic predict_byte(input logic [7:0] c, input logic eot);
      step_tokens.delete();
      if (eot) begin
         case (mode)
            M_WORD: close_word();
            M_NUMBER: begin
               if (acc_ovf) raise_error(EC_TOO_LARGE);
               else push_token(TK_INTEGER, EC_NONE, acc, '0, '0);
            end
            M_POINT: raise_error(EC_BAD_POINT);
            default: ;
         endcase
         push_token(TK_END, EC_NONE, '0, '0, '0);
         clear_state();
      end else begin
         case (mode)
            M_WORD: begin
               if (is_alpha(c) || is_digit(c) || c == "_") add_letter(c);
               else begin
                  close_word();
                  start_token(c);
               end
            end
            M_NUMBER: begin
               if (is_digit(c)) add_digit(c, 1'b0);
               else if (acc_ovf) raise_error(EC_TOO_LARGE);
               else begin
                  push_token(TK_INTEGER, EC_NONE, acc, '0, '0);
                  mode = M_IDLE;
                  start_token(c);
               end
            end
            M_POINT: point_byte(c);
            M_ERROR: ;
            default: start_token(c);
         endcase
      end
      if (step_tokens.size() > 0) step_tokens[step_tokens.size() - 1].last = 1'b1;
      foreach (step_tokens[i]) begin
         if (step_tokens[i].kind == TK_ERROR) error_tokens++;
         if (step_tokens[i].kind == TK_POINT) point_tokens++;
         token_queue.push_back(step_tokens[i]);
      end
   endtask

   task automatic compare_token();
      qct_result_type e;
      token_count++;
      if (token_queue.size() == 0) begin
         $error("unexpected token kind %0d", rsp_token_kind);
         fail_count++;
         return;
      end
      e = token_queue.pop_front();
      if (rsp_token_kind !== e.kind) begin
         $error("token_kind exp %0d got %0d", e.kind, rsp_token_kind); fail_count++;
      end
      if (rsp_error_cause !== e.cause) begin
         $error("error_cause exp %0d got %0d", e.cause, rsp_error_cause); fail_count++;
      end
      if (rsp_first_number !== e.first) begin
         $error("first_number exp %0d got %0d", $signed(e.first), rsp_first_number);
         fail_count++;
      end
      if (rsp_second_number !== e.second) begin
         $error("second_number exp %0d got %0d", $signed(e.second), rsp_second_number);
         fail_count++;
      end
      if (rsp_name_char !== e.name_char) begin
         $error("name_char exp %0h got %0h", e.name_char, rsp_name_char); fail_count++;
      end
      if (rsp_last_of_run !== e.last) begin
         $error("last_of_run exp %0b got %0b", e.last, rsp_last_of_run); fail_count++;
      end
   endtask

   initial begin
      fail_count = 0; token_count = 0; error_tokens = 0; point_tokens = 0;
      clear_state();
   end

   always @(posedge clock) begin
      if (reset) begin
         clear_state();
         token_queue.delete();
      end else begin
         if (rsp_valid && rsp_ready) compare_token();
         if (req_valid && req_ready) predict_byte(req_char_code, req_end_of_text);
      end
   end

endmodule

### tb/sv/query_command_tokenizer_core_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// query_command_tokenizer_core_test
// drives text bytes into the tokenizer with random gaps and back pressure;
// a checker beside the block predicts and compares every token
// ----------------------------------------------------------------------------
module query_command_tokenizer_core_test;
   import qct_pkg::*;

   localparam int WATCHDOG_LIMIT = 4000;
   localparam int ITEM_TARGET    = 300;

   logic               clock = 1'b0;
   logic               reset = 1'b1;
   logic               req_valid = 1'b0;
   logic               req_ready;
   logic [7:0]         req_char_code = '0;
   logic               req_end_of_text = 1'b0;
   logic               rsp_valid;
   logic               rsp_ready = 1'b0;
   logic [3:0]         rsp_token_kind;
   logic [1:0]         rsp_error_cause;
   logic signed [31:0] rsp_first_number;
   logic signed [31:0] rsp_second_number;
   logic [7:0]         rsp_name_char;
   logic               rsp_last_of_run;

   int  fail_count, pending_tokens, token_count, error_tokens, point_tokens;
   int  bytes_sent = 0;
   int  idle_cycles = 0;
   bit  sending_done = 0;
   bit  long_hold = 0;
   bit  timed_out = 0;

   // one entry per byte: bit 8 marks end of text
   logic [8:0] text_bytes[$];

   always #2 clock = ~clock;

   query_command_tokenizer_core dut (.*);

   query_command_tokenizer_core_checker checker_i (
      .clock, .reset, .req_valid, .req_ready, .req_char_code, .req_end_of_text,
      .rsp_valid, .rsp_ready, .rsp_token_kind, .rsp_error_cause,
      .rsp_first_number, .rsp_second_number, .rsp_name_char, .rsp_last_of_run,
      .fail_count, .pending_tokens, .token_count, .error_tokens, .point_tokens
   );

   // ---- text builders ----
   task automatic put_str(input string s);
      for (int i = 0; i < s.len(); i++) text_bytes.push_back({1'b0, s[i]});
   endtask

   task automatic put_eot();
      text_bytes.push_back({1'b1, 8'($urandom)});
   endtask

   function automatic string rand_space();
      case ($urandom_range(0, 6))
         0: return "\t";
         1: return "\n";
         2: return "";
         3: return "";
         default: return " ";
      endcase
   endfunction

   function automatic string rand_case(input string s);
      string r = s;
      for (int i = 0; i < r.len(); i++)
         if ($urandom_range(0, 1) && r[i] >= "a" && r[i] <= "z") r[i] = r[i] - 8'd32;
      return r;
   endfunction

   function automatic string rand_word();
      string r;
      string alpha = "abcdefghijklmnopqrstuvwxyzABCDEFGHIJKLMNOPQRSTUVWXYZ";
      string tail = "abcXYZ019_q";
      int n;
      n = ($urandom_range(0, 9) == 0) ? $urandom_range(28, 34) : $urandom_range(1, 6);
      r = "";
      r = {r, string'(alpha[$urandom_range(0, alpha.len() - 1)])};
      for (int i = 1; i < n; i++) r = {r, string'(tail[$urandom_range(0, tail.len() - 1)])};
      return r;
   endfunction

   function automatic string rand_number(input bit allow_zero_lead);
      int n;
      string r;
      case ($urandom_range(0, 5))
         0: return "2147483647";
         1: return "2147483648";
         2: return $sformatf("%0d", $urandom());
         default: begin
            n = $urandom_range(1, 5);
            r = $sformatf("%0d", $urandom_range(1, 9));
            for (int i = 1; i < n; i++) r = {r, $sformatf("%0d", $urandom_range(0, 9))};
            if (allow_zero_lead && $urandom_range(0, 5) == 0) r = {"0", r};
            return r;
         end
      endcase
   endfunction

   function automatic string rand_coord();
      string sign;
      case ($urandom_range(0, 3))
         0: sign = "-";
         1: sign = "+";
         default: sign = "";
      endcase
      if ($urandom_range(0, 5) == 0) return "0";
      if ($urandom_range(0, 9) == 0) return "-2147483648";
      return {sign, rand_number(0)};
   endfunction

   function automatic string rand_point();
      string r;
      r = {"(", rand_space(), rand_coord(), rand_space(), ",", rand_space(), rand_coord(),
           rand_space(), ")"};
      // occasionally break the pattern
      if ($urandom_range(0, 7) == 0) r[$urandom_range(1, r.len() - 1)] = "x";
      return r;
   endfunction

   function automatic string rand_keyword();
      case ($urandom_range(0, 8))
         0: return "create";
         1: return "insert";
         2: return {"print", "_tree"};
         3: return "contains";
         4: return "search";
         5: return "where";
         6: return "inside";
         7: return "left_of";
         default: return "nn";
      endcase
   endfunction

   // a mostly well-formed command with random content
   task automatic build_command();
      int parts;
      string s;
      parts = $urandom_range(1, 6);
      s = rand_case(rand_keyword());
      for (int i = 0; i < parts; i++) begin
         s = {s, rand_space() == "" ? " " : rand_space()};
         case ($urandom_range(0, 7))
            0, 1: s = {s, rand_word()};
            2: s = {s, rand_case(rand_keyword())};
            3: s = {s, rand_number(1)};
            4, 5: s = {s, rand_point()};
            6: s = {s, ","};
            default: s = {s, string'(8'($urandom_range(0, 255)))};
         endcase
      end
      if ($urandom_range(0, 1)) s = {s, ";"};
      put_str(s);
      if ($urandom_range(0, 3) == 0) text_bytes.push_back({1'b0, 8'($urandom_range(0, 255))});
      put_eot();
   endtask

   // noise: random bytes including every bit pattern
   task automatic build_noise();
      int n;
      n = $urandom_range(1, 6);
      for (int j = 0; j < n; j++) text_bytes.push_back({1'b0, 8'($urandom_range(0, 255))});
      put_eot();
   endtask

   // ---- directed texts ----
   task automatic build_directed();
      put_str({"CREATE insert Print", "_Tree contains search where inside LEFT_OF nn;"});
      put_eot();
      put_str("abcdefghijklmnopqrstuvwxyzABCDEF,"); put_eot();          // name at full length
      put_str("abcdefghijklmnopqrstuvwxyzABCDEFG"); put_eot();          // name too long
      put_str("007 2147483647 2147483648"); put_eot();                  // leading zeros, limit
      put_str("(0,0)(-2147483648 , +2147483647)"); put_eot();           // point extremes
      put_str("( 1 , 2"); put_eot();                                    // unterminated point
      put_str("(01,2)"); put_eot();                                     // leading zero in point
      put_str("(1,2147483648)"); put_eot();                             // coordinate too large
      put_str(")"); put_eot();                                          // lone close paren
      text_bytes.push_back({1'b0, 8'h00}); put_eot();                   // byte zero
      text_bytes.push_back({1'b0, 8'hff}); put_str("nn"); put_eot();    // high byte, ignored rest
      put_str("name_1"); put_eot();                                     // name flushed at end
      put_eot();                                                        // empty text
   endtask

   // ---- sender ----
   initial begin
      int gap;
      logic [8:0] b;
      build_directed();
      while (text_bytes.size() < ITEM_TARGET) begin
         if ($urandom_range(0, 3) == 0) build_noise();
         else build_command();
      end
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      while (text_bytes.size() > 0) begin
         b = text_bytes.pop_front();
         req_valid <= 1'b1;
         req_char_code <= b[7:0];
         req_end_of_text <= b[8];
         @(posedge clock);
         while (!req_ready) @(posedge clock);
         bytes_sent++;
         gap = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 4) : 0;
         if (text_bytes.size() == 0 || gap > 0) req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      sending_done = 1;
   end

   // ---- receiver ----
   initial begin
      int stall;
      @(negedge reset);
      forever begin
         if (bytes_sent > 40 && !long_hold) begin
            // long hold-off while the sender keeps offering bytes
            long_hold = 1;
            rsp_ready <= 1'b0;
            repeat (200) @(posedge clock);
         end
         stall = ($urandom_range(0, 2) == 0) ? $urandom_range(0, 4) : 0;
         if (stall > 0) begin
            rsp_ready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
         rsp_ready <= 1'b1;
         @(posedge clock);
         while (!rsp_valid) @(posedge clock);
      end
   end

   // ---- watchdog ----
   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready)) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
   end

   initial begin
      wait (idle_cycles >= WATCHDOG_LIMIT);
      timed_out = 1;
      $display("Verification failed");
      $finish;
   end

   // ---- verdict ----
   initial begin
      wait (sending_done);
      @(posedge clock);
      wait (pending_tokens == 0);
      repeat (100) @(posedge clock);
      if (timed_out) wait (0);
      $display("sent %0d bytes, checked %0d tokens (%0d errors, %0d points)",
               bytes_sent, token_count, error_tokens, point_tokens);
      if (fail_count == 0 && pending_tokens == 0) begin
         $display("Verification passed");
      end else begin
         $display("Verification failed");
      end
      $finish;
   end

endmodule

### sim.f
rtl/qct_pkg.sv
rtl/qct_ram.sv
rtl/qct_front.sv
rtl/qct_back.sv
rtl/query_command_tokenizer_core.sv
tb/sv/query_command_tokenizer_core_checker.sv
tb/sv/query_command_tokenizer_core_test.sv
